// ----- rtl/rtrt_pkg.sv -----
// Shared types and constants for the request timeout and retry table.
package rtrt_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned COUNT_W = 10;

  // Countdown loaded after reset, and the retry spacing in ticks
  localparam logic [COUNT_W-1:0] RESET_TIMEOUT = 10'd30;
  localparam logic [COUNT_W-1:0] RETRY_PERIOD  = 10'd10;

  // Reciprocal of the retry spacing: floor(c * 205 / 2048) == floor(c / 10)
  // for every 10-bit c
  localparam logic [7:0]  RECIP_MUL   = 8'd205;
  localparam int unsigned RECIP_SHIFT = 11;

  // Opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ISSUE  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  // Event kinds
  localparam logic [1:0] EV_TIMEOUT = 2'd0;
  localparam logic [1:0] EV_RETRY   = 2'd1;
  localparam logic [1:0] EV_QUERY   = 2'd2;
  localparam logic [1:0] EV_DONE    = 2'd3;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] request_id;
  } item_t;

  typedef struct packed {
    logic [1:0]      event_kind;
    logic [ID_W-1:0] event_id;
    logic            alive;
    logic            status;
    logic            last;
  } result_t;

  // Write controls from the sequencer to the table
  typedef struct packed {
    logic key_we;
    logic cnt_we;
    logic set_valid;
    logic clr_valid;
  } tbl_cmd_t;

  // Outputs of the shared slot unit
  typedef struct packed {
    logic [COUNT_W-1:0] cnt_next;
    logic               zero;
    logic               retry;
    logic               match;
  } unit_res_t;

endpackage

// ----- rtl/request_timeout_retry_table.sv -----
// Request timeout and retry table: top-level sequencer over the slot table and shared unit.
//
// Usage:
//   Input channel: start/busy. An item (opcode, request_id) is taken at a
//   clock edge with start high and busy low. busy stays high until the
//   item's last result has been put on the result ports.
//   Result channel: result_valid_o strobes for one cycle per result; the
//   receiver must take it then. The final result of an item has last set.
//   Configuration: cfg_we_i writes cfg_wdata_i into the issue countdown;
//   write only while busy is low.
//   Sequencing: the sequencer walks the slots one at a time through one memory
//   read port and one decrement/compare unit, with a read state and an event
//   state per slot. Issue, remove and query make one pass over the slots; a
//   tick makes two (a decrement pass, then a retry pass). Each result
//   appears in the cycle after the slot step that makes it; the last result
//   shows in the first cycle that busy is low again.
//   Reset: all slots free, countdown 30, no result pending. Key and count
//   memories are not cleared; the valid flops guard them.
module request_timeout_retry_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  rtrt_pkg::item_t               item_i,
  output logic                          result_valid_o,
  output rtrt_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [rtrt_pkg::COUNT_W-1:0]  cfg_wdata_i
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic                         pass_q, pass_d;
  logic [1:0]                   op_q, op_d;
  logic [rtrt_pkg::ID_W-1:0]    id_q, id_d;
  logic                         found_q, found_d;
  logic [IDX_W-1:0]             slot_q, slot_d;
  logic                         free_q, free_d;
  logic [IDX_W-1:0]             free_idx_q, free_idx_d;
  logic [TABLE_DEPTH-1:0]       retry_q, retry_d;
  logic [rtrt_pkg::COUNT_W-1:0] timeout_q;
  logic                         res_valid_q, res_valid_d;
  rtrt_pkg::result_t            res_q, res_d;

  logic                         rd_valid;
  logic [rtrt_pkg::ID_W-1:0]    rd_key;
  logic [rtrt_pkg::COUNT_W-1:0] rd_cnt;
  rtrt_pkg::tbl_cmd_t           cmd;
  logic [IDX_W-1:0]             wr_addr;
  logic [rtrt_pkg::ID_W-1:0]    wr_key;
  logic [rtrt_pkg::COUNT_W-1:0] wr_cnt;
  rtrt_pkg::unit_res_t          ures;
  logic [rtrt_pkg::COUNT_W-1:0] load_cnt;
  logic                         idx_last;
  logic                         accept;

  rtrt_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (idx_q),
    .rd_valid_o(rd_valid),
    .rd_key_o  (rd_key),
    .rd_cnt_o  (rd_cnt),
    .cmd_i     (cmd),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_cnt_i  (wr_cnt)
  );

  rtrt_unit u_unit (
    .cnt_i(rd_cnt),
    .key_i(rd_key),
    .id_i (id_q),
    .res_o(ures)
  );

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign idx_last = (idx_q == IDX_W'(TABLE_DEPTH - 1));
  // A zero countdown setting loads as one
  assign load_cnt = (timeout_q == '0) ? rtrt_pkg::COUNT_W'(1) : timeout_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pass_d      = pass_q;
    op_d        = op_q;
    id_d        = id_q;
    found_d     = found_q;
    slot_d      = slot_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    retry_d     = retry_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    cmd         = '0;
    wr_addr     = idx_q;
    wr_key      = id_q;
    wr_cnt      = ures.cnt_next;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = item_i.opcode;
          id_d    = item_i.request_id;
          idx_d   = '0;
          pass_d  = 1'b0;
          found_d = 1'b0;
          free_d  = 1'b0;
          retry_d = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        res_d.alive  = 1'b0;
        res_d.status = 1'b0;
        res_d.last   = 1'b0;
        res_d.event_id = rd_key;
        if (op_q == rtrt_pkg::OP_TICK) begin
          if (!pass_q) begin
            // Decrement pass: timeouts go out now, retries are flagged
            if (rd_valid) begin
              cmd.cnt_we = 1'b1;
              if (ures.zero) begin
                cmd.clr_valid    = 1'b1;
                res_valid_d      = 1'b1;
                res_d.event_kind = rtrt_pkg::EV_TIMEOUT;
              end else if (ures.retry) begin
                retry_d[idx_q] = 1'b1;
              end
            end
          end else if (retry_q[idx_q]) begin
            res_valid_d      = 1'b1;
            res_d.event_kind = rtrt_pkg::EV_RETRY;
          end
        end else begin
          // Lookup pass: first matching slot and first free slot
          if (rd_valid && ures.match && !found_q) begin
            found_d = 1'b1;
            slot_d  = idx_q;
          end
          if (!rd_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_q;
          end
        end
        if (idx_last) begin
          idx_d = '0;
          if (op_q == rtrt_pkg::OP_TICK && !pass_q) begin
            pass_d  = 1'b1;
            state_d = S_RD;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_RD;
        end
      end
      S_FIN: begin
        res_valid_d      = 1'b1;
        res_d.event_kind = rtrt_pkg::EV_DONE;
        res_d.event_id   = id_q;
        res_d.alive      = 1'b0;
        res_d.status     = 1'b0;
        res_d.last       = 1'b1;
        case (op_q)
          rtrt_pkg::OP_TICK: begin
            res_d.event_id = '0;
          end
          rtrt_pkg::OP_ISSUE: begin
            wr_cnt = load_cnt;
            if (found_q || free_q) begin
              wr_addr       = found_q ? slot_q : free_idx_q;
              cmd.key_we    = 1'b1;
              cmd.cnt_we    = 1'b1;
              cmd.set_valid = 1'b1;
            end else begin
              res_d.status = 1'b1;
            end
          end
          rtrt_pkg::OP_REMOVE: begin
            wr_addr       = slot_q;
            cmd.clr_valid = found_q;
          end
          default: begin
            res_d.event_kind = rtrt_pkg::EV_QUERY;
            res_d.alive      = found_q;
          end
        endcase
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pass_q      <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      retry_q     <= '0;
      res_valid_q <= 1'b0;
      timeout_q   <= rtrt_pkg::RESET_TIMEOUT;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pass_q      <= pass_d;
      found_q     <= found_d;
      free_q      <= free_d;
      retry_q     <= retry_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    slot_q     <= slot_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  // The final result of an item shows once the sequencer is back in idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |-> state_q == S_IDLE)
    else $error("last result while sequencer busy");

  // An intermediate result is always followed by more work
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> state_q != S_IDLE)
    else $error("non-final result with sequencer idle");

  // Only ticks run the retry pass
  a_pass_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q && state_q != S_IDLE |-> op_q == rtrt_pkg::OP_TICK)
    else $error("retry pass on a non-tick item");

  // Slot index stays inside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(TABLE_DEPTH - 1))
    else $error("slot index out of range");

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not start work");
`endif

endmodule

// ----- rtl/rtrt_table.sv -----
// Slot storage: key and countdown memories with one registered read port, plus valid flops.
module rtrt_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [IDX_W-1:0]              rd_addr_i,
  output logic                          rd_valid_o,
  output logic [rtrt_pkg::ID_W-1:0]     rd_key_o,
  output logic [rtrt_pkg::COUNT_W-1:0]  rd_cnt_o,
  input  rtrt_pkg::tbl_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]              wr_addr_i,
  input  logic [rtrt_pkg::ID_W-1:0]     wr_key_i,
  input  logic [rtrt_pkg::COUNT_W-1:0]  wr_cnt_i
);

  logic [rtrt_pkg::ID_W-1:0]    key_mem [TABLE_DEPTH];
  logic [rtrt_pkg::COUNT_W-1:0] cnt_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]       valid_q;
  logic [TABLE_DEPTH-1:0]       valid_d;
  logic                         rd_valid_q;
  logic [rtrt_pkg::ID_W-1:0]    rd_key_q;
  logic [rtrt_pkg::COUNT_W-1:0] rd_cnt_q;

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_we) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (cmd_i.cnt_we) begin
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[rd_addr_i];
    rd_cnt_q <= cnt_mem[rd_addr_i];
  end

  // Valid bits
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.set_valid) begin
      valid_d[wr_addr_i] = 1'b1;
    end
    if (cmd_i.clr_valid) begin
      valid_d[wr_addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_key_o   = rd_key_q;
  assign rd_cnt_o   = rd_cnt_q;

endmodule

// ----- rtl/rtrt_unit.sv -----
// Shared slot unit: countdown decrement, zero and retry checks, key compare.
module rtrt_unit (
  input  logic [rtrt_pkg::COUNT_W-1:0] cnt_i,
  input  logic [rtrt_pkg::ID_W-1:0]    key_i,
  input  logic [rtrt_pkg::ID_W-1:0]    id_i,
  output rtrt_pkg::unit_res_t          res_o
);

  logic [rtrt_pkg::COUNT_W-1:0] dec;
  logic [17:0]                  prod;
  logic [6:0]                   quot;
  logic [10:0]                  quot10;

  // Decrement with wrap
  assign dec = cnt_i - rtrt_pkg::COUNT_W'(1);

  // Divide by ten through the reciprocal, then multiply back with shifts
  assign prod   = 18'(dec) * 18'(rtrt_pkg::RECIP_MUL);
  assign quot   = prod[17:rtrt_pkg::RECIP_SHIFT];
  assign quot10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};

  always_comb begin
    res_o.cnt_next = dec;
    res_o.zero     = (dec == '0);
    res_o.retry    = (dec != '0) && ({1'b0, dec} == quot10);
    res_o.match    = (key_i == id_i);
  end

endmodule

// ----- tb/request_timeout_retry_table_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the request timeout and retry table: directed rows, then random phases.
module request_timeout_retry_table_tb;

  localparam int unsigned ID_W          = rtrt_pkg::ID_W;
  localparam int unsigned COUNT_W       = rtrt_pkg::COUNT_W;
  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned HALF_PERIOD   = 2;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned MAX_GAP       = 8;
  localparam int unsigned IDLE_SETTLE   = 3;
  localparam int unsigned END_SETTLE    = 4 * TABLE_DEPTH + 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned ID_POOL_SIZE  = 20;
  localparam int unsigned NUM_PHASES    = 6;

  typedef struct {
    rtrt_pkg::item_t   item;
    bit                typed;
    rtrt_pkg::result_t want;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  rtrt_pkg::item_t    item_i      = '0;
  logic               result_valid_o;
  rtrt_pkg::result_t  result_o;
  logic               cfg_we_i    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;

  // Local copy of the table and the issue countdown
  logic               slot_valid [TABLE_DEPTH];
  logic [ID_W-1:0]    slot_key   [TABLE_DEPTH];
  logic [COUNT_W-1:0] slot_count [TABLE_DEPTH];
  logic [COUNT_W-1:0] load_ticks;

  rtrt_pkg::result_t  events_due[$];
  stim_row_t          directed_rows[$];
  logic [ID_W-1:0]    id_pool [ID_POOL_SIZE];
  int unsigned        mismatches  = 0;
  int unsigned        cycle_count = 0;
  int unsigned        quiet_run   = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  request_timeout_retry_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic rtrt_pkg::result_t make_result(logic [1:0] kind, logic [ID_W-1:0] id,
                                                    logic alive, logic status, logic last);
    rtrt_pkg::result_t r;
    r.event_kind = kind;
    r.event_id   = id;
    r.alive      = alive;
    r.status     = status;
    r.last       = last;
    return r;
  endfunction

  // Appends one expected result behind the ones already waiting
  function automatic void queue_result(rtrt_pkg::result_t r);
    events_due = {events_due, r};
  endfunction

  function automatic int find_key(logic [ID_W-1:0] id);
    int s;
    s = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (s < 0 && slot_valid[i] && slot_key[i] == id) s = i;
    end
    return s;
  endfunction

  // Updates the table copy for one item and queues the events it causes
  function automatic void predict_events(rtrt_pkg::item_t it);
    logic [COUNT_W-1:0] c;
    logic               expired   [TABLE_DEPTH];
    logic               retry_due [TABLE_DEPTH];
    int                 s;
    logic               full;
    case (it.opcode)
      rtrt_pkg::OP_TICK: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          expired[i]   = 1'b0;
          retry_due[i] = 1'b0;
          if (slot_valid[i]) begin
            c = slot_count[i] - 1'b1;
            slot_count[i] = c;
            if (c == '0) expired[i] = 1'b1;
            else if (c % rtrt_pkg::RETRY_PERIOD == '0) retry_due[i] = 1'b1;
          end
        end
        // timeouts first, then retries, both in slot order
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (expired[i]) begin
            queue_result(make_result(rtrt_pkg::EV_TIMEOUT, slot_key[i], 1'b0, 1'b0, 1'b0));
            slot_valid[i] = 1'b0;
          end
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (retry_due[i])
            queue_result(make_result(rtrt_pkg::EV_RETRY, slot_key[i], 1'b0, 1'b0, 1'b0));
        end
        queue_result(make_result(rtrt_pkg::EV_DONE, '0, 1'b0, 1'b0, 1'b1));
      end
      rtrt_pkg::OP_ISSUE: begin
        s = find_key(it.request_id);
        // new id takes the lowest free slot
        if (s < 0) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (s < 0 && !slot_valid[i]) s = i;
          end
        end
        full = (s < 0);
        if (!full) begin
          slot_valid[s] = 1'b1;
          slot_key[s]   = it.request_id;
          // zero countdown loads as one
          slot_count[s] = (load_ticks == '0) ? COUNT_W'(1) : load_ticks;
        end
        queue_result(make_result(rtrt_pkg::EV_DONE, it.request_id, 1'b0, full, 1'b1));
      end
      rtrt_pkg::OP_REMOVE: begin
        s = find_key(it.request_id);
        if (s >= 0) slot_valid[s] = 1'b0;
        queue_result(make_result(rtrt_pkg::EV_DONE, it.request_id, 1'b0, 1'b0, 1'b1));
      end
      default: begin
        queue_result(make_result(rtrt_pkg::EV_QUERY, it.request_id,
                                 find_key(it.request_id) >= 0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // Directed row; typed rows carry their expected single result
  function automatic void add_row(logic [1:0] op, logic [ID_W-1:0] id, bit typed,
                                  logic alive, logic status);
    stim_row_t row;
    row.item.opcode     = op;
    row.item.request_id = id;
    row.typed           = typed;
    row.want = make_result((op == rtrt_pkg::OP_QUERY) ? rtrt_pkg::EV_QUERY : rtrt_pkg::EV_DONE,
                           (op == rtrt_pkg::OP_TICK) ? '0 : id, alive, status, 1'b1);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic rtrt_pkg::item_t random_item(int unsigned tick_pct);
    rtrt_pkg::item_t it;
    int unsigned     roll;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      it.opcode = rtrt_pkg::OP_TICK;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 5) it.opcode = rtrt_pkg::OP_ISSUE;
      else if (roll < 7) it.opcode = rtrt_pkg::OP_REMOVE;
      else it.opcode = rtrt_pkg::OP_QUERY;
    end
    // mostly a small pool so ids hit live entries and the table fills
    if ($urandom_range(0, 9) < 7) it.request_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
    else it.request_id = $urandom();
    return it;
  endfunction

  // Sender gap, with stretches of back-to-back items
  function automatic int unsigned draw_gap();
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      quiet_run = $urandom_range(4, 12);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Drives an item and returns at the edge that takes it
  task automatic send_item(input rtrt_pkg::item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_events(it);
  endtask

  task automatic pause_after(input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits for all expected results to arrive, then loads a new issue countdown
  task automatic write_timeout(input logic [COUNT_W-1:0] value);
    start <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    load_ticks   = value;
  endtask

  task automatic flag_field(input string name, input logic [ID_W-1:0] want_v,
                            input logic [ID_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Result checker: every strobe is compared with the oldest expectation
  always @(posedge clk_i) begin : check_results
    rtrt_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      if (events_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d id %h",
                 $time, result_o.event_kind, result_o.event_id);
        mismatches++;
      end else begin
        want = events_due.pop_front();
        flag_field("event_kind", ID_W'(want.event_kind), ID_W'(result_o.event_kind));
        flag_field("event_id",   want.event_id,          result_o.event_id);
        flag_field("alive",      ID_W'(want.alive),      ID_W'(result_o.alive));
        flag_field("status",     ID_W'(want.status),     ID_W'(result_o.status));
        flag_field("last",       ID_W'(want.last),       ID_W'(result_o.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, events_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase_timeout;
    int unsigned phase_items;
    int unsigned phase_tick_pct;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_count[i] = '0;
    end
    load_ticks = rtrt_pkg::RESET_TIMEOUT;

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < ID_POOL_SIZE; i++) id_pool[i] = $urandom();

    // Empty table, id extremes, restart of a present id, absent remove
    add_row(rtrt_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_TICK,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_ISSUE,  32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_ISSUE,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_ISSUE,  32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    add_row(rtrt_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 1'b0, 1'b0);
    // Fill the table, then issue a new id into it and restart a present one
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      add_row(rtrt_pkg::OP_ISSUE, 32'h1000_0000 + i, 1'b0, 1'b0, 1'b0);
    add_row(rtrt_pkg::OP_ISSUE,  32'hA5A5_5A5A, 1'b1, 1'b0, 1'b1);
    add_row(rtrt_pkg::OP_ISSUE,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item);
      if (directed_rows[r].typed) begin
        void'(events_due.pop_back());
        queue_result(directed_rows[r].want);
      end
      pause_after(draw_gap());
    end

    // Random phases, each under its own issue countdown
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          phase_timeout = 32'(rtrt_pkg::RESET_TIMEOUT); phase_items = 50; phase_tick_pct = 60;
        end
        1:       begin phase_timeout = 1;    phase_items = 30; phase_tick_pct = 35; end
        2:       begin phase_timeout = 0;    phase_items = 25; phase_tick_pct = 35; end
        3:       begin phase_timeout = 1023; phase_items = 25; phase_tick_pct = 30; end
        4:       begin phase_timeout = 12;   phase_items = 35; phase_tick_pct = 45; end
        default: begin phase_timeout = 25;   phase_items = 35; phase_tick_pct = 45; end
      endcase
      write_timeout(phase_timeout[COUNT_W-1:0]);
      for (int k = 0; k < phase_items; k++) begin
        send_item(random_item(phase_tick_pct));
        pause_after(draw_gap());
      end
    end

    start <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);

    if (mismatches == 0 && events_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
